// ----- design/overlap_box_suppression_unit_defines.svh -----
// Assertion macros used by the top-level design file.
`ifndef OVERLAP_BOX_SUPPRESSION_UNIT_DEFINES_SVH
`define OVERLAP_BOX_SUPPRESSION_UNIT_DEFINES_SVH

`ifndef SYNTH
`define OBSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obsu assertion failed");
`define OBSU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obsu assertion failed");
`else
`define OBSU_ASSERT_IMP(lbl, ante, cons)
`define OBSU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- design/obsu_pkg.sv -----
package obsu_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int PX_FRAC = 4;
    localparam int PX_W    = COORD_W - PX_FRAC;
    localparam int IDX_W   = 5;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } box_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        box_t               box;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic hit;
        logic replace;
    } cmp_res_t;

endpackage

// ----- design/obsu_ram.sv -----
module obsu_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/obsu_cmp.sv -----
module obsu_cmp
    import obsu_pkg::*;
(
    input  entry_t   cand,
    input  entry_t   kept,
    output cmp_res_t res
);

    logic apart;

    // shared edges count as touching
    always_comb
    begin
        apart = (cand.box.left > kept.box.right) || (kept.box.left > cand.box.right) ||
                (cand.box.top > kept.box.bottom) || (kept.box.top > cand.box.bottom);
        res.hit     = !apart;
        res.replace = !apart && (cand.score > kept.score);
    end

endmodule

// ----- design/overlap_box_suppression_unit.sv -----
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | command, confidence, left_x, top_y, right_x, bottom_y
// out     | output    | out_valid/out_stall | valid_res, face_index, score, *_px, last, overflow
//
// Offer: IDLE, then SCAN over the kept entries, then APPEND; a box of zero width or height
// is dropped in IDLE; one kept entry per cycle through the overlap comparator.
// Flush: per result a store read, then an output register load; a stall holds the read.
// Reset clears the kept count and overflow flag; store contents are not cleared.
// A held output register blocks only the next flush result, not offers.
`include "overlap_box_suppression_unit_defines.svh"

module overlap_box_suppression_unit
    import obsu_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [SCORE_W-1:0] confidence,
    input  logic [COORD_W-1:0] left_x,
    input  logic [COORD_W-1:0] top_y,
    input  logic [COORD_W-1:0] right_x,
    input  logic [COORD_W-1:0] bottom_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               valid_res,
    output logic [IDX_W-1:0]   face_index,
    output logic [SCORE_W-1:0] score,
    output logic [PX_W-1:0]    left_px,
    output logic [PX_W-1:0]    top_px,
    output logic [PX_W-1:0]    right_px,
    output logic [PX_W-1:0]    bottom_px,
    output logic               last,
    output logic               overflow
);

    localparam int AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_APPEND = 3'd2;
    localparam logic [2:0] S_FL_RD  = 3'd3;
    localparam logic [2:0] S_FL_LD  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    entry_t           new_reg, new_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             hit_any_reg, hit_any_next;
    logic             repl_any_reg, repl_any_next;
    logic [CNT_W-1:0] fl_idx_reg, fl_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic               valid_res_reg, valid_res_next;
    logic [IDX_W-1:0]   face_index_reg, face_index_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [PX_W-1:0]    left_px_reg, left_px_next;
    logic [PX_W-1:0]    top_px_reg, top_px_next;
    logic [PX_W-1:0]    right_px_reg, right_px_next;
    logic [PX_W-1:0]    bottom_px_reg, bottom_px_next;
    logic               last_reg, last_next;
    logic               overflow_reg, overflow_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    cmp_res_t         cmp_res;
    logic             fl_last;

    obsu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    obsu_cmp u_cmp (
        .cand (new_reg),
        .kept (ram_rdata),
        .res  (cmp_res)
    );

    assign fl_last = (cnt_reg == '0) || ((fl_idx_reg + CNT_W'(1)) == cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        new_next        = new_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        chk_vld_next    = chk_vld_reg;
        hit_any_next    = hit_any_reg;
        repl_any_next   = repl_any_reg;
        fl_idx_next     = fl_idx_reg;
        out_valid_next  = out_valid_reg;
        valid_res_next  = valid_res_reg;
        face_index_next = face_index_reg;
        score_next      = score_reg;
        left_px_next    = left_px_reg;
        top_px_next     = top_px_reg;
        right_px_next   = right_px_reg;
        bottom_px_next  = bottom_px_reg;
        last_next       = last_reg;
        overflow_next   = overflow_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = rd_ptr_reg[AW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_FLUSH)
                    begin
                        fl_idx_next = '0;
                        state_next  = S_FL_RD;
                    end
                    else if ((left_x != right_x) && (top_y != bottom_y))
                    begin
                        new_next.score      = confidence;
                        new_next.box.left   = left_x;
                        new_next.box.top    = top_y;
                        new_next.box.right  = right_x;
                        new_next.box.bottom = bottom_y;
                        rd_ptr_next         = '0;
                        wr_ptr_next         = '0;
                        chk_vld_next        = 1'b0;
                        hit_any_next        = 1'b0;
                        repl_any_next       = 1'b0;
                        state_next          = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // read runs at least one entry ahead of the compacting write
                if (rd_ptr_reg < cnt_reg)
                begin
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    if (cmp_res.hit)
                    begin
                        hit_any_next = 1'b1;
                    end
                    if (cmp_res.replace)
                    begin
                        repl_any_next = 1'b1;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end
                if (!chk_vld_reg && (rd_ptr_reg == cnt_reg))
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cnt_next = wr_ptr_reg;
                if (!hit_any_reg || repl_any_reg)
                begin
                    if (wr_ptr_reg >= CNT_W'(MAX_BOXES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = new_reg;
                        cnt_next  = wr_ptr_reg + CNT_W'(1);
                    end
                end
                state_next = S_IDLE;
            end
            S_FL_RD:
            begin
                ram_raddr = fl_idx_reg[AW-1:0];
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_FL_LD;
                end
            end
            S_FL_LD:
            begin
                out_valid_next  = 1'b1;
                overflow_next   = ovf_reg;
                last_next       = fl_last;
                if (cnt_reg == '0)
                begin
                    valid_res_next  = 1'b0;
                    face_index_next = '0;
                    score_next      = '0;
                    left_px_next    = '0;
                    top_px_next     = '0;
                    right_px_next   = '0;
                    bottom_px_next  = '0;
                end
                else
                begin
                    valid_res_next  = 1'b1;
                    face_index_next = IDX_W'(fl_idx_reg);
                    score_next      = ram_rdata.score;
                    left_px_next    = ram_rdata.box.left[COORD_W-1:PX_FRAC];
                    top_px_next     = ram_rdata.box.top[COORD_W-1:PX_FRAC];
                    right_px_next   = ram_rdata.box.right[COORD_W-1:PX_FRAC];
                    bottom_px_next  = ram_rdata.box.bottom[COORD_W-1:PX_FRAC];
                end
                if (fl_last)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    fl_idx_next = fl_idx_reg + CNT_W'(1);
                    state_next  = S_FL_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg        <= new_next;
        rd_ptr_reg     <= rd_ptr_next;
        wr_ptr_reg     <= wr_ptr_next;
        hit_any_reg    <= hit_any_next;
        repl_any_reg   <= repl_any_next;
        fl_idx_reg     <= fl_idx_next;
        valid_res_reg  <= valid_res_next;
        face_index_reg <= face_index_next;
        score_reg      <= score_next;
        left_px_reg    <= left_px_next;
        top_px_reg     <= top_px_next;
        right_px_reg   <= right_px_next;
        bottom_px_reg  <= bottom_px_next;
        last_reg       <= last_next;
        overflow_reg   <= overflow_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign valid_res  = valid_res_reg;
    assign face_index = face_index_reg;
    assign score      = score_reg;
    assign left_px    = left_px_reg;
    assign top_px     = top_px_reg;
    assign right_px   = right_px_reg;
    assign bottom_px  = bottom_px_reg;
    assign last       = last_reg;
    assign overflow   = overflow_reg;

    `OBSU_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(MAX_BOXES))
    `OBSU_ASSERT_IMP(a_wr_behind_rd, state_reg == S_SCAN, wr_ptr_reg <= rd_ptr_reg)
    `OBSU_ASSERT_NXT(a_flush_clears, (state_reg == S_FL_LD) && fl_last, (cnt_reg == '0) && !ovf_reg)
    `OBSU_ASSERT_IMP(a_out_load, $rose(out_valid_reg), $past(state_reg) == S_FL_LD)

endmodule

// ----- test/tb_overlap_box_suppression_unit.sv -----
`timescale 1ns / 1ps

module tb_overlap_box_suppression_unit;
    import obsu_pkg::*;

    localparam int STORE_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 100;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;

    typedef struct {
        logic               cmd;
        logic [SCORE_W-1:0] conf;
        box_t               box;
    } det_item_t;

    typedef struct {
        logic               valid_res;
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        logic [PX_W-1:0]    left;
        logic [PX_W-1:0]    top;
        logic [PX_W-1:0]    right;
        logic [PX_W-1:0]    bottom;
        logic               last;
        logic               ovf;
    } face_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic [SCORE_W-1:0] confidence;
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] top_y;
    logic [COORD_W-1:0] right_x;
    logic [COORD_W-1:0] bottom_y;
    logic               out_valid;
    logic               out_stall;
    logic               valid_res;
    logic [IDX_W-1:0]   face_index;
    logic [SCORE_W-1:0] score;
    logic [PX_W-1:0]    left_px;
    logic [PX_W-1:0]    top_px;
    logic [PX_W-1:0]    right_px;
    logic [PX_W-1:0]    bottom_px;
    logic               last;
    logic               overflow;

    det_item_t          pending_dets[$];
    face_res_t          faces_due[$];
    face_res_t          want;

    logic [SCORE_W-1:0] store_conf[STORE_DEPTH];
    box_t               store_box[STORE_DEPTH];
    int                 store_count;
    bit                 store_ovf;

    int                 error_count;
    int                 idle_cycles;
    int                 burst_left;
    int                 gap_left;
    int                 hold_left;
    bit                 hold_done;
    int                 taken_in;
    int                 stall_mode;
    int                 mode_left;
    int                 stall_tick;

    overlap_box_suppression_unit #(
        .MAX_BOXES (STORE_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .confidence (confidence),
        .left_x     (left_x),
        .top_y      (top_y),
        .right_x    (right_x),
        .bottom_y   (bottom_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .valid_res  (valid_res),
        .face_index (face_index),
        .score      (score),
        .left_px    (left_px),
        .top_px     (top_px),
        .right_px   (right_px),
        .bottom_px  (bottom_px),
        .last       (last),
        .overflow   (overflow)
    );

    always #5 clk = ~clk;

    function automatic bit boxes_meet(box_t a, box_t b);
        return !(a.left > b.right || b.left > a.right || a.top > b.bottom || b.top > a.bottom);
    endfunction

    task automatic suppress_overlaps(input logic [SCORE_W-1:0] conf, input box_t nb);
        int  i;
        int  w;
        int  hits;
        int  removed;
        bit  meet;
        if (nb.left == nb.right || nb.top == nb.bottom)
            return;
        w       = 0;
        hits    = 0;
        removed = 0;
        for (i = 0; i < store_count; i++)
        begin
            meet = boxes_meet(nb, store_box[i]);
            if (meet)
                hits++;
            if (meet && conf > store_conf[i])
                removed++;
            else
            begin
                store_conf[w] = store_conf[i];
                store_box[w]  = store_box[i];
                w++;
            end
        end
        store_count = w;
        if (hits == 0 || removed > 0)
        begin
            if (store_count >= STORE_DEPTH)
                store_ovf = 1'b1;
            else
            begin
                store_conf[store_count] = conf;
                store_box[store_count]  = nb;
                store_count++;
            end
        end
    endtask

    task automatic flush_kept_boxes();
        face_res_t f;
        int        i;
        if (store_count == 0)
        begin
            f.valid_res = 1'b0;
            f.idx       = '0;
            f.score     = '0;
            f.left      = '0;
            f.top       = '0;
            f.right     = '0;
            f.bottom    = '0;
            f.last      = 1'b1;
            f.ovf       = store_ovf;
            faces_due.insert(faces_due.size(), f);
        end
        for (i = 0; i < store_count; i++)
        begin
            f.valid_res = 1'b1;
            f.idx       = IDX_W'(i);
            f.score     = store_conf[i];
            f.left      = PX_W'(store_box[i].left >> PX_FRAC);
            f.top       = PX_W'(store_box[i].top >> PX_FRAC);
            f.right     = PX_W'(store_box[i].right >> PX_FRAC);
            f.bottom    = PX_W'(store_box[i].bottom >> PX_FRAC);
            f.last      = (i == store_count - 1);
            f.ovf       = store_ovf;
            faces_due.insert(faces_due.size(), f);
        end
        store_count = 0;
        store_ovf   = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic queue_offer(input int conf, input int l, input int t, input int r,
                               input int b);
        det_item_t d;
        d.cmd        = CMD_OFFER;
        d.conf       = SCORE_W'(conf);
        d.box.left   = COORD_W'(l);
        d.box.top    = COORD_W'(t);
        d.box.right  = COORD_W'(r);
        d.box.bottom = COORD_W'(b);
        pending_dets.insert(pending_dets.size(), d);
    endtask

    task automatic queue_flush();
        det_item_t d;
        d.cmd  = CMD_FLUSH;
        d.conf = SCORE_W'($urandom);
        d.box  = box_t'({$urandom, $urandom});
        pending_dets.insert(pending_dets.size(), d);
    endtask

    task automatic queue_random_offer(input bit spread);
        int conf;
        int l;
        int t;
        int r;
        int b;
        int pick;
        pick = $urandom_range(0, 9);
        conf = ($urandom_range(0, 3) == 0) ? ($urandom_range(1, 3) << 14)
                                           : $urandom_range(0, 65535);
        if (pick == 0)
        begin
            l = $urandom_range(0, 65535);
            t = $urandom_range(0, 65535);
            r = ($urandom_range(0, 1) == 0) ? l : $urandom_range(0, 65535);
            b = (r == l) ? $urandom_range(0, 65535) : t;
        end
        else if (pick == 1)
        begin
            l = $urandom_range(0, 65535);
            t = $urandom_range(0, 65535);
            r = $urandom_range(0, 65535);
            b = $urandom_range(0, 65535);
        end
        else if (spread)
        begin
            l = ($urandom_range(0, 63) << 10) | $urandom_range(0, 255);
            t = ($urandom_range(0, 63) << 10) | $urandom_range(0, 255);
            r = l + $urandom_range(1, 767);
            b = t + $urandom_range(1, 767);
        end
        else
        begin
            l = $urandom_range(0, 3072);
            t = $urandom_range(0, 3072);
            r = l + $urandom_range(1, 768);
            b = t + $urandom_range(1, 768);
        end
        queue_offer(conf, l, t, r, b);
    endtask

    initial
    begin
        int i;
        int frame_len;
        int random_done;
        bit spread;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_OFFER;
        confidence = '0;
        left_x     = '0;
        top_y      = '0;
        right_x    = '0;
        bottom_y   = '0;
        out_stall  = 1'b0;
        error_count = 0;
        store_count = 0;
        store_ovf   = 1'b0;

        // directed: empty flush, degenerate boxes, shared edge, equal and lower
        // confidence, inverted box, extremes
        queue_flush();
        queue_offer(16'h8000, 16'h0100, 16'h0100, 16'h0100, 16'h0200);
        queue_offer(16'h8000, 16'h0100, 16'h0100, 16'h0200, 16'h0100);
        queue_offer(16'h8000, 16'h0100, 16'h0100, 16'h0200, 16'h0200);
        queue_offer(16'h7FFF, 16'h0200, 16'h0200, 16'h0300, 16'h0300);
        queue_offer(16'h8000, 16'h0180, 16'h0180, 16'h0280, 16'h0280);
        queue_offer(16'h0000, 16'h1000, 16'h1000, 16'h100F, 16'h100F);
        queue_offer(16'hFFFF, 16'h01F0, 16'h0000, 16'h0210, 16'h0101);
        queue_offer(16'h0001, 16'h9000, 16'h9000, 16'h8000, 16'hA000);
        queue_offer(16'h0002, 16'h8800, 16'h9800, 16'h8900, 16'h9900);
        queue_flush();
        queue_offer(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_offer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        queue_offer(16'h5555, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF);
        queue_flush();

        // fill the store, overflow on one more, then a replacement still fits
        for (i = 0; i <= STORE_DEPTH; i++)
            queue_offer(16'h1000 + i, i * 16'h0600, 16'h0010, i * 16'h0600 + 16'h0100, 16'h0100);
        queue_offer(16'hFFFF, 16'h0000, 16'h0020, 16'h0080, 16'h0080);
        queue_flush();
        queue_flush();

        random_done = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                frame_len = $urandom_range(20, 40);
            else
                frame_len = $urandom_range(0, 10);
            spread = (frame_len >= 20) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < frame_len; i++)
                queue_random_offer(spread);
            if ($urandom_range(0, 9) != 0)
                queue_flush();
            random_done += frame_len + 1;
        end
        queue_flush();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_dets.size() != 0)
            @(posedge clk);
        while (faces_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && faces_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // sender: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                void'(pending_dets.pop_front());
            if (in_valid && in_stall)
            begin
                // held until transfer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_dets.size() != 0)
            begin
                in_valid   <= 1'b1;
                command    <= pending_dets[0].cmd;
                confidence <= pending_dets[0].conf;
                left_x     <= pending_dets[0].box.left;
                top_y      <= pending_dets[0].box.top;
                right_x    <= pending_dets[0].box.right;
                bottom_y   <= pending_dets[0].box.bottom;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern in phases, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  = 0;
            hold_done  = 1'b0;
            taken_in   = 0;
            stall_mode = 0;
            mode_left  = 0;
            stall_tick = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                taken_in++;
            stall_tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && taken_in >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(10, 80);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (stall_tick % 3 == 0);
                endcase
            end
        end
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (command == CMD_FLUSH)
                    flush_kept_boxes();
                else
                    suppress_overlaps(confidence, box_t'({bottom_y, right_x, top_y, left_x}));
            end
            if (out_valid && !out_stall)
            begin
                if (faces_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end
                else
                begin
                    want = faces_due.pop_front();
                    check_field("valid_res", 16'(want.valid_res), 16'(valid_res));
                    check_field("face_index", 16'(want.idx), 16'(face_index));
                    check_field("score", want.score, score);
                    check_field("left_px", 16'(want.left), 16'(left_px));
                    check_field("top_px", 16'(want.top), 16'(top_px));
                    check_field("right_px", 16'(want.right), 16'(right_px));
                    check_field("bottom_px", 16'(want.bottom), 16'(bottom_px));
                    check_field("last", 16'(want.last), 16'(last));
                    check_field("overflow", 16'(want.ovf), 16'(overflow));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
+incdir+design
design/obsu_pkg.sv
design/obsu_ram.sv
design/obsu_cmp.sv
design/overlap_box_suppression_unit.sv
test/tb_overlap_box_suppression_unit.sv
